// File: rtl/core/spms_pkg.sv
package spms_pkg;

    localparam int DEF_MAX_STACKS = 16;
    localparam int DEF_POOL_DEPTH = 256;
    localparam int DEF_WORD_WIDTH = 32;

    localparam int CMD_W      = 3;
    localparam int SEL_W      = 4;
    localparam int DEPTH_W    = 8;
    localparam int STATUS_W   = 2;
    localparam int STK_CFG_W  = 5;
    localparam int POOL_CFG_W = 9;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;

    typedef logic [CMD_W-1:0]     cmd_t;
    typedef logic [STATUS_W-1:0]  status_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cmd_t CMD_PUSH        = 3'd0;
    localparam cmd_t CMD_POP         = 3'd1;
    localparam cmd_t CMD_RESET_STACK = 3'd2;
    localparam cmd_t CMD_RESET_ALL   = 3'd3;
    localparam cmd_t CMD_CHECK       = 3'd4;
    localparam cmd_t CMD_PEEK        = 3'd5;

    localparam status_t STAT_OK      = 2'd0;
    localparam status_t STAT_BAD_SEL = 2'd1;
    localparam status_t STAT_NO_NODE = 2'd2;
    localparam status_t STAT_EMPTY   = 2'd3;

    localparam cfg_idx_t CFG_STACKS = 1'd0;
    localparam cfg_idx_t CFG_POOL   = 1'd1;

    localparam logic [STK_CFG_W-1:0]  RST_STACKS_CFG = 5'd16;
    localparam logic [POOL_CFG_W-1:0] RST_POOL_CFG   = 9'd256;

endpackage

// File: rtl/core/spms_ram.sv
module spms_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
)
(
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/shared_pool_multi_stack.sv
// Channel | Dir | Handshake          | Payload
// s_      | in  | s_tvalid/s_tready  | s_tdata: command, stack_select, data_in, peek_depth
// m_      | out | m_tvalid/m_tready  | m_tdata: status, data_out, check_ok, stack_count, free_count
// cfg_    | in  | cfg_valid/cfg_ready| cfg_index, cfg_data (0 stacks_in_use, 1 pool_in_use)
//
// One item at a time. Push, reset-all, errors and empty cases pass through accept, table read,
// execute and result load; pop adds a node read after the stack table read.
// Reset-stack walks every node of the stack, check at most that many (it stops at the first zero
// word), peek walks down to its depth: one node read per link.
// Reset acts as reset-all with register values 16 and 256; no clearing pass, a fill mark
// stands in for the ordered free chain. A stalled result holds the next item in its load cycle.
module shared_pool_multi_stack
    import spms_pkg::*;
#(
    parameter int MAX_STACKS = DEF_MAX_STACKS,
    parameter int POOL_DEPTH = DEF_POOL_DEPTH,
    parameter int WORD_WIDTH = DEF_WORD_WIDTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // command, stack_select, data_in, peek_depth
    input  logic [((CMD_W + SEL_W + WORD_WIDTH + DEPTH_W + 7) / 8) * 8 - 1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // status, data_out, check_ok, stack_count, free_count
    output logic [((STATUS_W + WORD_WIDTH + 1 + 2 * $clog2(POOL_DEPTH + 1) + 7) / 8) * 8 - 1:0]
                 m_tdata,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int AW     = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int CW     = $clog2(POOL_DEPTH + 1);
    localparam int SW     = (MAX_STACKS > 1) ? $clog2(MAX_STACKS) : 1;
    localparam int NW     = AW + WORD_WIDTH;
    localparam int SE     = AW + CW;
    localparam int OUT_TW = ((STATUS_W + WORD_WIDTH + 1 + 2 * CW + 7) / 8) * 8;
    localparam int RST_LIVE_STACKS = (MAX_STACKS < 16) ? MAX_STACKS : 16;
    localparam int RST_FREE        = (POOL_DEPTH < 256) ? POOL_DEPTH : 256;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_POP  = 3'd2;
    localparam logic [2:0] S_WALK = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    logic [2:0]            state_reg, state_next;
    logic [STK_CFG_W-1:0]  stacks_cfg_reg, stacks_cfg_next;
    logic [POOL_CFG_W-1:0] pool_cfg_reg, pool_cfg_next;
    logic [STK_CFG_W-1:0]  live_stacks_reg, live_stacks_next;
    logic [MAX_STACKS-1:0] stk_vld_reg, stk_vld_next;
    logic [AW-1:0]         free_head_reg, free_head_next;
    logic [CW-1:0]         free_cnt_reg, free_cnt_next;
    logic [CW-1:0]         wm_reg, wm_next;
    logic                  m_tvalid_reg, m_tvalid_next;

    cmd_t                  cmd_reg, cmd_next;
    logic [SW-1:0]         sel_reg, sel_next;
    logic                  sel_ok_reg, sel_ok_next;
    logic                  vld_q_reg, vld_q_next;
    logic [WORD_WIDTH-1:0] data_reg, data_next;
    logic [DEPTH_W-1:0]    depth_reg, depth_next;
    logic [AW-1:0]         hd_reg, hd_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [CW-1:0]         k_reg, k_next;
    logic [CW-1:0]         tgt_reg, tgt_next;
    logic [AW-1:0]         rd_addr_reg;
    status_t               res_status_reg, res_status_next;
    logic [WORD_WIDTH-1:0] res_dout_reg, res_dout_next;
    logic                  res_ok_reg, res_ok_next;
    logic [CW-1:0]         res_scount_reg, res_scount_next;
    logic [OUT_TW-1:0]     m_tdata_reg, m_tdata_next;

    cmd_t                  in_cmd;
    logic [SEL_W-1:0]      in_sel;
    logic [SW-1:0]         in_sel_idx;
    logic                  in_sel_ok;
    logic [WORD_WIDTH-1:0] in_data;
    logic [DEPTH_W-1:0]    in_depth;

    logic                  node_we;
    logic [AW-1:0]         node_waddr;
    logic [NW-1:0]         node_wdata;
    logic [AW-1:0]         node_raddr;
    logic [NW-1:0]         node_rdata;
    logic [AW-1:0]         rd_next;
    logic [WORD_WIDTH-1:0] rd_word;
    logic [AW-1:0]         rd_link;

    logic                  stk_we;
    logic [SE-1:0]         stk_wdata;
    logic [SW-1:0]         stk_raddr;
    logic [SE-1:0]         stk_rdata;
    logic [AW-1:0]         s_head;
    logic [CW-1:0]         s_cnt;

    function automatic logic [AW-1:0] nxt_of(input logic [AW-1:0] a, input logic [AW-1:0] lnk,
                                             input logic [CW-1:0] wm);
        logic fresh;
        fresh = (CW'(a) >= wm);
        if (!fresh)
        begin
            return lnk;
        end
        if (32'(a) + 32'd1 >= 32'(POOL_DEPTH))
        begin
            return '0;
        end
        return AW'(32'(a) + 32'd1);
    endfunction

    spms_ram #(
        .WIDTH(NW),
        .DEPTH(POOL_DEPTH)
    ) u_node_ram (
        .clk  (clk),
        .we   (node_we),
        .waddr(node_waddr),
        .wdata(node_wdata),
        .raddr(node_raddr),
        .rdata(node_rdata)
    );

    spms_ram #(
        .WIDTH(SE),
        .DEPTH(MAX_STACKS)
    ) u_stack_ram (
        .clk  (clk),
        .we   (stk_we),
        .waddr(sel_reg),
        .wdata(stk_wdata),
        .raddr(stk_raddr),
        .rdata(stk_rdata)
    );

    assign in_cmd     = s_tdata[CMD_W-1:0];
    assign in_sel     = s_tdata[CMD_W +: SEL_W];
    assign in_data    = s_tdata[CMD_W + SEL_W +: WORD_WIDTH];
    assign in_depth   = s_tdata[CMD_W + SEL_W + WORD_WIDTH +: DEPTH_W];
    assign in_sel_idx = SW'(in_sel);
    assign in_sel_ok  = (32'(in_sel) < 32'(live_stacks_reg)) && (32'(in_sel) < MAX_STACKS);

    assign rd_next = node_rdata[WORD_WIDTH +: AW];
    assign rd_word = node_rdata[WORD_WIDTH-1:0];
    assign rd_link = nxt_of(rd_addr_reg, rd_next, wm_reg);
    assign s_head  = vld_q_reg ? stk_rdata[CW +: AW] : '0;
    assign s_cnt   = vld_q_reg ? stk_rdata[CW-1:0] : '0;

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    always_comb
    begin
        state_next       = state_reg;
        stacks_cfg_next  = stacks_cfg_reg;
        pool_cfg_next    = pool_cfg_reg;
        live_stacks_next = live_stacks_reg;
        stk_vld_next     = stk_vld_reg;
        free_head_next   = free_head_reg;
        free_cnt_next    = free_cnt_reg;
        wm_next          = wm_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_tdata_next     = m_tdata_reg;
        cmd_next         = cmd_reg;
        sel_next         = sel_reg;
        sel_ok_next      = sel_ok_reg;
        vld_q_next       = vld_q_reg;
        data_next        = data_reg;
        depth_next       = depth_reg;
        hd_next          = hd_reg;
        cnt_next         = cnt_reg;
        k_next           = k_reg;
        tgt_next         = tgt_reg;
        res_status_next  = res_status_reg;
        res_dout_next    = res_dout_reg;
        res_ok_next      = res_ok_reg;
        res_scount_next  = res_scount_reg;
        node_we          = 1'b0;
        node_waddr       = rd_addr_reg;
        node_wdata       = {free_head_reg, rd_word};
        node_raddr       = rd_addr_reg;
        stk_we           = 1'b0;
        stk_wdata        = '0;
        stk_raddr        = sel_reg;

        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_STACKS: stacks_cfg_next = cfg_data[STK_CFG_W-1:0];
                CFG_POOL:   pool_cfg_next   = cfg_data[POOL_CFG_W-1:0];
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                node_raddr = free_head_reg;
                stk_raddr  = in_sel_idx;
                cmd_next    = in_cmd;
                sel_next    = in_sel_idx;
                sel_ok_next = in_sel_ok;
                vld_q_next  = in_sel_ok ? stk_vld_reg[in_sel_idx] : 1'b0;
                data_next   = in_data;
                depth_next  = in_depth;
                if (s_tvalid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                hd_next         = s_head;
                cnt_next        = s_cnt;
                k_next          = '0;
                node_raddr      = s_head;
                state_next      = S_EMIT;
                res_status_next = STAT_OK;
                res_dout_next   = '0;
                res_ok_next     = 1'b0;
                res_scount_next = s_cnt;
                priority if (cmd_reg == CMD_RESET_ALL)
                begin
                    live_stacks_next = (32'(stacks_cfg_reg) > MAX_STACKS) ?
                                       STK_CFG_W'(MAX_STACKS) : stacks_cfg_reg;
                    free_cnt_next    = (32'(pool_cfg_reg) > POOL_DEPTH) ?
                                       CW'(POOL_DEPTH) : CW'(pool_cfg_reg);
                    stk_vld_next     = '0;
                    free_head_next   = '0;
                    wm_next          = '0;
                    res_scount_next  = '0;
                end
                else if (!sel_ok_reg && cmd_reg <= CMD_PEEK)
                begin
                    res_status_next = STAT_BAD_SEL;
                    res_scount_next = '0;
                end
                else
                begin
                    unique case (cmd_reg)
                        CMD_PUSH:
                        begin
                            if (free_cnt_reg == '0)
                            begin
                                res_status_next = STAT_NO_NODE;
                            end
                            else
                            begin
                                node_we         = 1'b1;
                                node_waddr      = free_head_reg;
                                node_wdata      = {s_head, data_reg};
                                stk_we          = 1'b1;
                                stk_wdata       = {free_head_reg, s_cnt + CW'(1)};
                                stk_vld_next[sel_reg] = 1'b1;
                                free_head_next  = nxt_of(free_head_reg, rd_next, wm_reg);
                                free_cnt_next   = free_cnt_reg - CW'(1);
                                if (CW'(free_head_reg) >= wm_reg)
                                begin
                                    wm_next = wm_reg + CW'(1);
                                end
                                res_scount_next = s_cnt + CW'(1);
                            end
                        end
                        CMD_POP:
                        begin
                            if (s_cnt == '0)
                            begin
                                res_status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                state_next = S_POP;
                            end
                        end
                        CMD_RESET_STACK, CMD_CHECK:
                        begin
                            res_ok_next = (cmd_reg == CMD_CHECK);
                            if (s_cnt != '0)
                            begin
                                tgt_next   = s_cnt - CW'(1);
                                state_next = S_WALK;
                            end
                        end
                        CMD_PEEK:
                        begin
                            if (32'(depth_reg) >= 32'(s_cnt))
                            begin
                                res_status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                tgt_next   = CW'(depth_reg);
                                state_next = S_WALK;
                            end
                        end
                        default:
                        begin
                            res_status_next = STAT_OK;
                        end
                    endcase
                end
            end
            S_POP:
            begin
                node_we         = 1'b1;
                node_waddr      = rd_addr_reg;
                node_wdata      = {free_head_reg, rd_word};
                stk_we          = 1'b1;
                stk_wdata       = {rd_link, cnt_reg - CW'(1)};
                free_head_next  = rd_addr_reg;
                free_cnt_next   = free_cnt_reg + CW'(1);
                res_dout_next   = rd_word;
                res_scount_next = cnt_reg - CW'(1);
                state_next      = S_EMIT;
            end
            S_WALK:
            begin
                priority if (cmd_reg == CMD_CHECK && rd_word == '0)
                begin
                    res_ok_next = 1'b0;
                    state_next  = S_EMIT;
                end
                else if (k_reg == tgt_reg)
                begin
                    state_next = S_EMIT;
                    if (cmd_reg == CMD_PEEK)
                    begin
                        res_dout_next = rd_word;
                    end
                    if (cmd_reg == CMD_RESET_STACK)
                    begin
                        node_we         = 1'b1;
                        node_waddr      = rd_addr_reg;
                        node_wdata      = {free_head_reg, rd_word};
                        stk_we          = 1'b1;
                        stk_wdata       = '0;
                        free_head_next  = hd_reg;
                        free_cnt_next   = free_cnt_reg + cnt_reg;
                        res_scount_next = '0;
                    end
                end
                else
                begin
                    node_raddr = rd_link;
                    k_next     = k_reg + CW'(1);
                end
            end
            S_EMIT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = OUT_TW'({free_cnt_reg, res_scount_reg, res_ok_reg,
                                             res_dout_reg, res_status_reg});
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            stacks_cfg_reg  <= RST_STACKS_CFG;
            pool_cfg_reg    <= RST_POOL_CFG;
            live_stacks_reg <= STK_CFG_W'(RST_LIVE_STACKS);
            stk_vld_reg     <= '0;
            free_head_reg   <= '0;
            free_cnt_reg    <= CW'(RST_FREE);
            wm_reg          <= '0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            stacks_cfg_reg  <= stacks_cfg_next;
            pool_cfg_reg    <= pool_cfg_next;
            live_stacks_reg <= live_stacks_next;
            stk_vld_reg     <= stk_vld_next;
            free_head_reg   <= free_head_next;
            free_cnt_reg    <= free_cnt_next;
            wm_reg          <= wm_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        sel_reg        <= sel_next;
        sel_ok_reg     <= sel_ok_next;
        vld_q_reg      <= vld_q_next;
        data_reg       <= data_next;
        depth_reg      <= depth_next;
        hd_reg         <= hd_next;
        cnt_reg        <= cnt_next;
        k_reg          <= k_next;
        tgt_reg        <= tgt_next;
        rd_addr_reg    <= node_raddr;
        res_status_reg <= res_status_next;
        res_dout_reg   <= res_dout_next;
        res_ok_reg     <= res_ok_next;
        res_scount_reg <= res_scount_next;
        m_tdata_reg    <= m_tdata_next;
    end

    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(free_cnt_reg) <= POOL_DEPTH) && (32'(wm_reg) <= POOL_DEPTH))
        else $error("free count or fill mark beyond pool");

    a_walk_target: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (k_reg <= tgt_reg))
        else $error("walk passed its target");

    a_push_node: assert property (@(posedge clk) disable iff (!rst_n)
        (node_we && state_reg == S_EXEC) |-> (free_cnt_reg != '0))
        else $error("node taken from empty free list");

    a_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && (!m_tvalid_reg || m_tready)) |=>
        (m_tvalid_reg && state_reg == S_IDLE))
        else $error("result not loaded");

    a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
        stk_we |-> (node_we || (state_reg == S_WALK && cmd_reg == CMD_RESET_STACK)))
        else $error("stack table written without node update");

endmodule
